@@ hw/rtl/sdpd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpd_pkg
// Types and constants shared by the PDU decoder modules.
// ----------------------------------------------------------------------------
package sdpd_pkg;

  localparam int unsigned RES_MAX = 4;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [1:0] STREAM_SENDER = 2'd0;
  localparam logic [1:0] STREAM_BODY   = 2'd1;
  localparam logic [1:0] STREAM_END    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_BAD_HDR   = 2'd3;

  localparam logic [1:0] ALPH_GSM7 = 2'd0;
  localparam logic [1:0] ALPH_8BIT = 2'd1;
  localparam logic [1:0] ALPH_UCS2 = 2'd2;
  localparam logic [1:0] ALPH_RSVD = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] stream;
    logic [1:0] status;
    logic       end_of_message;
  } result_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    result_t [RES_MAX-1:0]      res;
  } bundle_t;

endpackage

@@ hw/rtl/sdpd_in_if.sv @@
// ----------------------------------------------------------------------------
// sdpd_in_if
// PDU octet channel.
// ----------------------------------------------------------------------------
interface sdpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pdu_byte;
  logic       last;

  modport source (output valid, output pdu_byte, output last, input ready);
  modport sink   (input valid, input pdu_byte, input last, output ready);
endinterface

@@ hw/rtl/sdpd_out_if.sv @@
// ----------------------------------------------------------------------------
// sdpd_out_if
// Decoded text and status channel.
// ----------------------------------------------------------------------------
interface sdpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] stream;
  logic [1:0] status;
  logic       end_of_message;

  modport source (output valid, output out_byte, output stream, output status,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input stream, input status,
                  input end_of_message, output ready);
endinterface

@@ hw/rtl/sdpd_front.sv @@
// ----------------------------------------------------------------------------
// sdpd_front
// PDU field parser: turns each octet into a bundle of up to four words.
// ----------------------------------------------------------------------------
module sdpd_front import sdpd_pkg::*; #(
  parameter int unsigned MAX_PDU_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] pdu_byte_i,
  input  logic       last_i,
  input  logic       space_i,
  output logic       ready_o,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam int unsigned BCW = $clog2(MAX_PDU_BYTES + 1);
  localparam logic [BCW-1:0] BC_MAX = BCW'(MAX_PDU_BYTES);
  localparam logic [BCW-1:0] BC_MIN = BCW'(12);

  typedef enum logic [3:0] {
    PH_SCA_LEN, PH_SCA_SKIP, PH_FIRST, PH_OA_LEN, PH_TOA, PH_OA, PH_PID,
    PH_DCS, PH_SCTS, PH_UDL, PH_UDHL, PH_UDH_SKIP, PH_BODY, PH_DRAIN
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [BCW-1:0] bc_q, bc_d;
  logic [7:0]     skip_q, skip_d, digits_q, digits_d, units_q, units_d, hh_q, hh_d;
  logic           hdr_q, hdr_d, bits_ucs_q, bits_ucs_d;
  logic [1:0]     alph_q, alph_d, err_q, err_d;
  logic [13:0]    acc_q, acc_d;
  logic [3:0]     bits_q, bits_d;

  logic           accept;
  logic [2:0]     n;
  bundle_t        bnd;
  logic [3:0]     lo, hi;
  logic [8:0]     total;
  logic [11:0]    x8, x8p6;
  logic [24:0]    prod_used, prod_q;
  logic [8:0]     used, q7;
  logic [11:0]    rem7;
  logic [2:0]     fill;
  logic [15:0]    cp;
  logic [13:0]    acc_t;
  logic [4:0]     bits_t;
  logic [1:0]     st;

  function automatic logic [7:0] gsm_char(input logic [6:0] s);
    if (s >= 7'h20 && s <= 7'h7E) return {1'b0, s};
    if (s == 7'h0A || s == 7'h0D) return {1'b0, s};
    if (s == 7'h00) return 8'h40;
    return 8'h3F;
  endfunction

  assign ready_o  = space_i;
  assign accept   = valid_i && space_i;
  assign push_o   = accept && (n != 3'd0);
  assign bundle_o = bnd;

  assign lo        = pdu_byte_i[3:0];
  assign hi        = pdu_byte_i[7:4];
  assign total     = {1'b0, pdu_byte_i} + 9'd1;
  assign x8        = {total, 3'b000};
  assign x8p6      = x8 + 12'd6;
  assign prod_used = 25'(x8p6) * 25'd4682;
  assign prod_q    = 25'(x8) * 25'd4682;
  assign used      = prod_used[23:15];
  assign q7        = prod_q[23:15];
  assign rem7      = x8 - 12'(q7) * 12'd7;
  assign fill      = (rem7[2:0] == 3'd0) ? 3'd0 : 3'd7 - rem7[2:0];
  assign cp        = {hh_q, pdu_byte_i};

  always_comb begin
    phase_d    = phase_q;
    bc_d       = bc_q;
    skip_d     = skip_q;
    digits_d   = digits_q;
    units_d    = units_q;
    hh_d       = hh_q;
    hdr_d      = hdr_q;
    bits_ucs_d = bits_ucs_q;
    alph_d     = alph_q;
    err_d      = err_q;
    acc_d      = acc_q;
    bits_d     = bits_q;
    n          = 3'd0;
    bnd        = '0;
    acc_t      = '0;
    bits_t     = '0;
    st         = ST_OK;

    if (bc_q >= BC_MAX) begin
      if (err_q == ST_OK) err_d = ST_TRUNCATED;
    end else begin
      bc_d = bc_q + 1'b1;
      unique case (phase_q)
        PH_SCA_LEN: begin
          skip_d  = pdu_byte_i;
          phase_d = (pdu_byte_i != 8'd0) ? PH_SCA_SKIP : PH_FIRST;
        end
        PH_SCA_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_FIRST;
        end
        PH_FIRST: begin
          hdr_d   = pdu_byte_i[6];
          phase_d = PH_OA_LEN;
        end
        PH_OA_LEN: begin
          digits_d = pdu_byte_i;
          phase_d  = PH_TOA;
        end
        PH_TOA: begin
          if ((pdu_byte_i & 8'h70) == 8'h10) begin
            bnd.res[n[1:0]] = '{out_byte: 8'h2B, stream: STREAM_SENDER,
                                status: ST_OK, end_of_message: 1'b0};
            n = n + 3'd1;
          end
          skip_d  = 8'((9'(digits_q) + 9'd1) >> 1);
          phase_d = (skip_d != 8'd0) ? PH_OA : PH_PID;
        end
        PH_OA: begin
          if (digits_d != 8'd0 && lo <= 4'd9) begin
            bnd.res[n[1:0]] = '{out_byte: {4'h3, lo}, stream: STREAM_SENDER,
                                status: ST_OK, end_of_message: 1'b0};
            n = n + 3'd1;
            digits_d = digits_d - 8'd1;
          end
          if (digits_d != 8'd0 && hi <= 4'd9) begin
            bnd.res[n[1:0]] = '{out_byte: {4'h3, hi}, stream: STREAM_SENDER,
                                status: ST_OK, end_of_message: 1'b0};
            n = n + 3'd1;
            digits_d = digits_d - 8'd1;
          end
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_PID;
        end
        PH_PID: phase_d = PH_DCS;
        PH_DCS: begin
          if (pdu_byte_i[7:6] == 2'b00) alph_d = pdu_byte_i[3:2];
          else if (pdu_byte_i[7:6] == 2'b10) alph_d = ALPH_UCS2;
          else alph_d = ALPH_GSM7;
          if (alph_d == ALPH_RSVD) alph_d = ALPH_GSM7;
          skip_d  = 8'd7;
          phase_d = PH_SCTS;
        end
        PH_SCTS: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_UDL;
        end
        PH_UDL: begin
          units_d    = pdu_byte_i;
          acc_d      = '0;
          bits_d     = '0;
          bits_ucs_d = 1'b0;
          hh_d       = '0;
          if (hdr_q) begin
            phase_d = PH_UDHL;
          end else begin
            if (alph_q == ALPH_UCS2) units_d = pdu_byte_i >> 1;
            phase_d = PH_BODY;
          end
        end
        PH_UDHL: begin
          if (alph_q == ALPH_GSM7) begin
            if (9'(units_q) < used) begin
              err_d   = ST_BAD_HDR;
              phase_d = PH_DRAIN;
            end else begin
              units_d = 8'(9'(units_q) - used);
              hh_d    = {5'd0, fill};
            end
          end else begin
            if (9'(units_q) < total) begin
              err_d   = ST_BAD_HDR;
              phase_d = PH_DRAIN;
            end else begin
              units_d = 8'(9'(units_q) - total);
              if (alph_q == ALPH_UCS2) units_d = units_d >> 1;
            end
          end
          if (phase_d != PH_DRAIN) begin
            skip_d  = pdu_byte_i;
            phase_d = (pdu_byte_i != 8'd0) ? PH_UDH_SKIP : PH_BODY;
          end
        end
        PH_UDH_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (units_q != 8'd0) begin
            if (alph_q == ALPH_8BIT) begin
              units_d = units_q - 8'd1;
              bnd.res[0] = '{out_byte: pdu_byte_i, stream: STREAM_BODY,
                             status: ST_OK, end_of_message: 1'b0};
              n = 3'd1;
            end else if (alph_q == ALPH_UCS2) begin
              if (!bits_ucs_q) begin
                hh_d       = pdu_byte_i;
                bits_ucs_d = 1'b1;
              end else begin
                bits_ucs_d = 1'b0;
                units_d    = units_q - 8'd1;
                if (cp <= 16'h007F) begin
                  bnd.res[0] = '{out_byte: cp[7:0], stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  n = 3'd1;
                end else if (cp <= 16'h07FF) begin
                  bnd.res[0] = '{out_byte: {3'b110, cp[10:6]}, stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  bnd.res[1] = '{out_byte: {2'b10, cp[5:0]}, stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  n = 3'd2;
                end else begin
                  bnd.res[0] = '{out_byte: {4'b1110, cp[15:12]}, stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  bnd.res[1] = '{out_byte: {2'b10, cp[11:6]}, stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  bnd.res[2] = '{out_byte: {2'b10, cp[5:0]}, stream: STREAM_BODY,
                                 status: ST_OK, end_of_message: 1'b0};
                  n = 3'd3;
                end
              end
            end else begin
              acc_t  = acc_q | (14'(pdu_byte_i) << bits_q);
              bits_t = 5'(bits_q) + 5'd8;
              if (hh_q != 8'd0) begin
                acc_t  = acc_t >> hh_q[2:0];
                bits_t = bits_t - 5'(hh_q[2:0]);
                hh_d   = 8'd0;
              end
              for (int i = 0; i < 2; i++) begin
                if (bits_t >= 5'd7 && units_d != 8'd0) begin
                  bnd.res[n[1:0]] = '{out_byte: gsm_char(acc_t[6:0]),
                                      stream: STREAM_BODY, status: ST_OK,
                                      end_of_message: 1'b0};
                  n       = n + 3'd1;
                  acc_t   = acc_t >> 7;
                  bits_t  = bits_t - 5'd7;
                  units_d = units_d - 8'd1;
                end
              end
              acc_d  = acc_t;
              bits_d = bits_t[3:0];
            end
          end
        end
        default: ;
      endcase
    end

    if (last_i) begin
      if (bc_d < BC_MIN) st = ST_SHORT;
      else if (err_d != ST_OK) st = err_d;
      else if (phase_d <= PH_UDL) st = ST_TRUNCATED;
      else if (phase_d == PH_UDH_SKIP) st = ST_BAD_HDR;
      else st = ST_OK;
      bnd.res[n[1:0]] = '{out_byte: 8'h00, stream: STREAM_END, status: st,
                          end_of_message: 1'b1};
      n          = n + 3'd1;
      phase_d    = PH_SCA_LEN;
      bc_d       = '0;
      skip_d     = '0;
      digits_d   = '0;
      units_d    = '0;
      hh_d       = '0;
      hdr_d      = 1'b0;
      bits_ucs_d = 1'b0;
      alph_d     = ALPH_GSM7;
      err_d      = ST_OK;
      acc_d      = '0;
      bits_d     = '0;
    end
    bnd.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCA_LEN;
      bc_q       <= '0;
      skip_q     <= '0;
      digits_q   <= '0;
      units_q    <= '0;
      hh_q       <= '0;
      hdr_q      <= 1'b0;
      bits_ucs_q <= 1'b0;
      alph_q     <= ALPH_GSM7;
      err_q      <= ST_OK;
      acc_q      <= '0;
      bits_q     <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      bc_q       <= bc_d;
      skip_q     <= skip_d;
      digits_q   <= digits_d;
      units_q    <= units_d;
      hh_q       <= hh_d;
      hdr_q      <= hdr_d;
      bits_ucs_q <= bits_ucs_d;
      alph_q     <= alph_d;
      err_q      <= err_d;
      acc_q      <= acc_d;
      bits_q     <= bits_d;
    end
  end

endmodule

@@ hw/rtl/sdpd_queue.sv @@
// ----------------------------------------------------------------------------
// sdpd_queue
// Short bundle queue between the parser and the serialiser.
// ----------------------------------------------------------------------------
module sdpd_queue import sdpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    space_o,
  input  logic    pop_i,
  output logic    avail_o,
  output bundle_t head_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  bundle_t [QDEPTH-1:0] mem_q;
  logic [PW-1:0]        wr_q, rd_q;
  logic [CW-1:0]        cnt_q;
  logic                 do_push, do_pop;

  assign space_o = (cnt_q != CW'(QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hw/rtl/sdpd_back.sv @@
// ----------------------------------------------------------------------------
// sdpd_back
// Serialiser: hands out the words of the head bundle one at a time.
// ----------------------------------------------------------------------------
module sdpd_back import sdpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  bundle_t head_i,
  output logic    pop_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t word_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire, final_word;

  assign valid_o    = avail_i;
  assign word_o     = head_i.res[idx_q];
  assign fire       = avail_i && ready_i;
  assign final_word = ({1'b0, idx_q} == head_i.cnt - 3'd1);
  assign pop_o      = fire && final_word;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = final_word ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

endmodule

@@ hw/rtl/sms_deliver_pdu_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// sms_deliver_pdu_decoder_unit
// SMS-DELIVER PDU decoder: sender digits and UTF-8 body from binary octets.
// ----------------------------------------------------------------------------
// One PDU octet is taken per cycle while the two-entry bundle queue has room;
// the parser classifies it in that cycle and queues all of its output words
// (none to four). The serialiser drains one word per cycle while the output
// is ready: a UCS2 character yields up to three words, a GSM pair two, and
// the last octet adds the end word. Errors appear only in the status of the
// end-of-message word; no clearing pass follows reset.
module sms_deliver_pdu_decoder_unit import sdpd_pkg::*; #(
  parameter int unsigned MAX_PDU_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  sdpd_in_if.sink    in_i,
  sdpd_out_if.source out_o
);

  logic    space, push, pop, avail;
  bundle_t bnd, head;
  result_t word;

  sdpd_front #(.MAX_PDU_BYTES(MAX_PDU_BYTES)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .pdu_byte_i(in_i.pdu_byte), .last_i(in_i.last),
    .space_i(space), .ready_o(in_i.ready), .push_o(push), .bundle_o(bnd)
  );

  sdpd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .bundle_i(bnd), .space_o(space),
    .pop_i(pop), .avail_o(avail), .head_o(head)
  );

  sdpd_back u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .head_i(head), .pop_o(pop),
    .valid_o(out_o.valid), .ready_i(out_o.ready), .word_o(word)
  );

  assign out_o.out_byte       = word.out_byte;
  assign out_o.stream         = word.stream;
  assign out_o.status         = word.status;
  assign out_o.end_of_message = word.end_of_message;

endmodule
